// ===== rtl/bcc_pkg.sv =====
// Shared types and constants for the battery coulomb counter.
`default_nettype none

package bcc_pkg;

  // Field and register widths
  localparam int CURRENT_BITS_DEFAULT = 20;
  localparam int TIME_W     = 27;
  localparam int USED_W     = 56;
  localparam int TTL_W      = 32;
  localparam int TWICE_W    = 58;
  localparam int NUM_W      = 59;
  localparam int FULL_W     = 43;
  localparam int K_W        = 23;
  localparam int CAP_W      = 20;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam int DIV_STEPS  = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PERCENT  = 1'b1;

  // Reset values and scale factors
  localparam logic [CAP_W-1:0]  CAP_RESET   = 20'd123000;
  localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;
  localparam logic [K_W-1:0]    K_PER_PCT   = 23'd72000;    // 2 * 3600000 / 100
  localparam logic [FULL_W-1:0] MS2_PER_MAH = 43'd7200000;  // 2 * 3600000

  localparam logic [TWICE_W-1:0] TWICE_MAX = {1'b0, {(TWICE_W-1){1'b1}}};
  localparam logic [TWICE_W-1:0] TWICE_MIN = {1'b1, {(TWICE_W-1){1'b0}}};
  localparam logic [USED_W-1:0]  OUT_MAX   = {1'b0, {(USED_W-1){1'b1}}};
  localparam logic [USED_W-1:0]  OUT_MIN   = {1'b1, {(USED_W-1){1'b0}}};

  // Commands from controller to datapath
  typedef struct packed {
    logic init_k;
    logic init_used;
    logic init_full;
    logic load;
    logic mul;
    logic acc;
    logic num;
    logic chk;
    logic div_step;
    logic out_load;
  } bcc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic skip_div;
  } bcc_status_t;

endpackage

`default_nettype wire

// ===== rtl/bcc_ctrl.sv =====
// Controller state machine sequencing restart, integration and division.
`default_nettype none

module bcc_ctrl
  import bcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_we,
  input  bcc_status_t status,
  output bcc_cmd_t    cmd
);

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [3:0] {
    S_INIT_K, S_INIT_USED, S_INIT_FULL, S_IDLE,
    S_MUL, S_ACC, S_NUM, S_CHK, S_DIV, S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Decode commands from the current state
  always_comb begin
    cmd           = '0;
    cmd.init_k    = (state == S_INIT_K);
    cmd.init_used = (state == S_INIT_USED);
    cmd.init_full = (state == S_INIT_FULL);
    cmd.load      = s_tvalid && s_tready;
    cmd.mul       = (state == S_MUL);
    cmd.acc       = (state == S_ACC);
    cmd.num       = (state == S_NUM);
    cmd.chk       = (state == S_CHK);
    cmd.div_step  = (state == S_DIV);
    cmd.out_load  = (state == S_DONE) && out_free;
  end

  // Advance state, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT_K;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Raise valid when a result is loaded without a register write, drop it on its transfer
      if (cmd.out_load && !cfg_we) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        state <= S_INIT_K;
      end else begin
        case (state)
          S_INIT_K:    state <= S_INIT_USED;
          S_INIT_USED: state <= S_INIT_FULL;
          S_INIT_FULL: state <= S_IDLE;
          S_IDLE:      if (s_tvalid) state <= S_MUL;
          S_MUL:       state <= S_ACC;
          S_ACC:       state <= S_NUM;
          S_NUM:       state <= S_CHK;
          S_CHK: begin
            cnt <= '0;
            state <= status.skip_div ? S_DONE : S_DIV;
          end
          S_DIV: begin
            cnt <= cnt + 1'b1;
            if (cnt == DIV_LAST) state <= S_DONE;
          end
          S_DONE: begin
            if (out_free) state <= S_IDLE;
          end
          default: state <= S_INIT_K;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bcc_dp.sv =====
// Datapath: registers, trapezoid integrator, estimate numerator and serial divider.
`default_nettype none

module bcc_dp
  import bcc_pkg::*;
#(
  parameter int CURRENT_BITS = CURRENT_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bcc_cmd_t                       cmd,
  output bcc_status_t                    status,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic signed [CURRENT_BITS-1:0] in_current,
  input  logic [TIME_W-1:0]              in_time,
  output logic [USED_W-1:0]              out_used,
  output logic                           out_charging,
  output logic [TTL_W-1:0]               out_ttl,
  output logic                           out_no_estimate
);

  localparam int CB     = CURRENT_BITS;
  localparam int DW     = CB + 1;                        // divisor width
  localparam int PROD_W = CB + 1 + TIME_W + 1;
  localparam int SUM_W  = ((PROD_W > TWICE_W) ? PROD_W : TWICE_W) + 1;
  localparam int CMP_W  = ((DW + TTL_W > NUM_W) ? DW + TTL_W : NUM_W);

  // Configuration and restart values
  logic [CAP_W-1:0]  cap_mah;
  logic [PCT_W-1:0]  pct;
  logic [K_W-1:0]    k_reg;
  logic [FULL_W-1:0] full2;
  logic [PCT_W-1:0]  pct_clamp;

  // Integrator state
  logic signed [TWICE_W-1:0] used;
  logic signed [CB-1:0]      prev_cur;
  logic [TIME_W-1:0]         prev_time;
  logic                      have_prev;

  // Per-item working registers
  logic signed [CB-1:0]     cur_r;
  logic signed [CB:0]       sum_r;
  logic [TIME_W-1:0]        dt_r;
  logic                     acc_en;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [DW-1:0]            den_r;
  logic [USED_W-1:0]        half_r;
  logic                     chg_r;
  logic                     zero_r;
  logic [DW-1:0]            rem;
  logic [TTL_W-1:0]         nlo;
  logic [TTL_W-1:0]         quo;

  // Combinational helpers
  logic signed [SUM_W-1:0] acc_sum;
  logic                    acc_fits;
  logic signed [CB:0]      cur_ext;
  logic [CB:0]             cur_mag;
  logic [USED_W-1:0]       half_sat;
  logic                    num_nonpos;
  logic                    q_sat;
  logic [DW:0]             shifted;
  logic                    ge;

  assign pct_clamp = (pct > PCT_FULL) ? PCT_FULL : pct;

  // Saturating accumulate of the trapezoid area
  assign acc_sum  = SUM_W'(used) + SUM_W'(prod_r);
  assign acc_fits = (&acc_sum[SUM_W-1:TWICE_W-1]) || !(|acc_sum[SUM_W-1:TWICE_W-1]);

  // Magnitude of the present current and the halved, clamped charge
  assign cur_ext  = {cur_r[CB-1], cur_r};
  assign cur_mag  = cur_ext[CB] ? $unsigned(-cur_ext) : $unsigned(cur_ext);
  assign half_sat = (used[TWICE_W-1] == used[TWICE_W-2]) ? used[TWICE_W-2:1]
                  : (used[TWICE_W-1] ? OUT_MIN : OUT_MAX);

  // Decide whether the divider runs at all
  assign num_nonpos = num_r[NUM_W-1] || (num_r == '0);
  assign q_sat      = CMP_W'(num_r[NUM_W-2:0]) >= CMP_W'({den_r, {TTL_W{1'b0}}});
  assign status.skip_div = zero_r || num_nonpos || q_sat;

  // Restoring division step, one quotient bit per cycle
  assign shifted = {rem, nlo[TTL_W-1]};
  assign ge      = shifted >= {1'b0, den_r};

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_mah <= CAP_RESET;
      pct     <= PCT_FULL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPACITY: cap_mah <= cfg_data[CAP_W-1:0];
        REG_PERCENT:  pct     <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Track whether a previous sample exists
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (cmd.init_k) begin
      have_prev <= 1'b0;
    end else if (cmd.load) begin
      have_prev <= 1'b1;
    end
  end

  // Restart values, integration and divider datapath
  always_ff @(posedge clk) begin
    if (cmd.init_k) begin
      k_reg     <= K_PER_PCT * K_W'(PCT_FULL - pct_clamp);
      prev_cur  <= '0;
      prev_time <= '0;
    end
    if (cmd.init_used) used  <= $signed(TWICE_W'(cap_mah * FULL_W'(k_reg)));
    if (cmd.init_full) full2 <= cap_mah * MS2_PER_MAH;

    // Capture the sample, its trapezoid height and the elapsed time
    if (cmd.load) begin
      cur_r     <= in_current;
      sum_r     <= (CB+1)'(prev_cur) + (CB+1)'(in_current);
      dt_r      <= (in_time >= prev_time) ? in_time - prev_time : '0;
      acc_en    <= have_prev;
      prev_cur  <= in_current;
      prev_time <= in_time;
    end

    if (cmd.mul) prod_r <= PROD_W'(sum_r) * PROD_W'($signed({1'b0, dt_r}));

    if (cmd.acc && acc_en) begin
      used <= acc_fits ? acc_sum[TWICE_W-1:0]
            : (acc_sum[SUM_W-1] ? $signed(TWICE_MIN) : $signed(TWICE_MAX));
    end

    // Form numerator, divisor and the flag fields
    if (cmd.num) begin
      num_r  <= cur_r[CB-1] ? NUM_W'(used)
              : $signed({{(NUM_W-FULL_W){1'b0}}, full2}) - NUM_W'(used);
      den_r  <= {cur_mag[CB-1:0], 1'b0};
      half_r <= half_sat;
      chg_r  <= cur_r[CB-1];
      zero_r <= (cur_r == '0);
    end

    // Seed the divider or settle the estimate directly
    if (cmd.chk) begin
      rem <= DW'(num_r[NUM_W-1:TTL_W]);
      nlo <= num_r[TTL_W-1:0];
      quo <= (zero_r || num_nonpos) ? '0 : (q_sat ? '1 : '0);
    end

    if (cmd.div_step) begin
      rem <= ge ? DW'(shifted - {1'b0, den_r}) : shifted[DW-1:0];
      nlo <= {nlo[TTL_W-2:0], 1'b0};
      quo <= {quo[TTL_W-2:0], ge};
    end

    // Output register
    if (cmd.out_load) begin
      out_used        <= half_r;
      out_charging    <= chg_r;
      out_ttl         <= quo;
      out_no_estimate <= zero_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/battery_coulomb_counter_top.sv =====
// Top level of the battery coulomb counter: stream ports, controller and datapath.
// After an input transfer the controller steps through S_MUL, S_ACC, S_NUM and S_CHK,
//   then, when the estimate is divided out, the divider (32 divider steps, one quotient bit
//   per cycle) and S_DONE, which waits for a free output; only S_IDLE takes samples.
// Reset and every register write recompute the starting charge with s_tready low.
// Reset: synchronous on rst, capacity 123000 mAh, initial charge 100 percent.
`default_nettype none

module battery_coulomb_counter_top
  import bcc_pkg::*;
#(
  parameter int CURRENT_BITS = CURRENT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [CURRENT_BITS-1:0] sample_current_ma, then sample_time_ms, zero padded to bytes
  input  logic [((CURRENT_BITS+TIME_W+7)/8)*8-1:0] s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [55:0] used_charge_mams, [87:56] time_to_limit_ms
  output logic [USED_W+TTL_W-1:0] m_tdata,
  // [0] charging, [1] no_estimate
  output logic [1:0]            m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bcc_cmd_t    cmd;
  bcc_status_t status;

  logic [USED_W-1:0] out_used;
  logic [TTL_W-1:0]  out_ttl;
  logic              out_charging;
  logic              out_no_estimate;

  assign m_tdata = {out_ttl, out_used};
  assign m_tuser = {out_no_estimate, out_charging};

  bcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .status   (status),
    .cmd      (cmd)
  );

  bcc_dp #(
    .CURRENT_BITS (CURRENT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_current      ($signed(s_tdata[CURRENT_BITS-1:0])),
    .in_time         (s_tdata[CURRENT_BITS+TIME_W-1:CURRENT_BITS]),
    .out_used        (out_used),
    .out_charging    (out_charging),
    .out_ttl         (out_ttl),
    .out_no_estimate (out_no_estimate)
  );

endmodule

`default_nettype wire

// ===== verif/bcc_checker.sv =====
// Checker for the coulomb counter: tracks configuration, predicts each reading and compares it.
module bcc_checker
  import bcc_pkg::*;
#(
  parameter int CURRENT_BITS = CURRENT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // [CURRENT_BITS-1:0] sample_current_ma, then sample_time_ms, zero padded to bytes
  input  logic [((CURRENT_BITS+TIME_W+7)/8)*8-1:0] s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // [55:0] used_charge_mams, [87:56] time_to_limit_ms
  input  logic [USED_W+TTL_W-1:0] m_tdata,
  // [0] charging, [1] no_estimate
  input  logic [1:0]            m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    failures,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Accumulator and output limits, milliseconds per hour and doubled charge per percent of one mAh
  localparam longint TWICE_HI       = 64'sh01FF_FFFF_FFFF_FFFF;
  localparam longint TWICE_LO       = -TWICE_HI - 1;
  localparam longint OUT_HI         = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint OUT_LO         = -OUT_HI - 1;
  localparam longint TTL_TOP        = 64'sh0000_0000_FFFF_FFFF;
  localparam longint MS_PER_HOUR    = 3600000;
  localparam longint CHARGE_PER_PCT = 72000;

  typedef struct packed {
    logic [USED_W-1:0] used;
    logic              charging;
    logic [TTL_W-1:0]  ttl;
    logic              no_estimate;
  } gauge_reading_t;

  // Gauge state as the block should hold it
  logic [CAP_W-1:0] cap_mah;
  logic [PCT_W-1:0] pct;
  longint           twice_used;
  longint           prev_ma;
  longint           prev_ms;
  bit               have_prev;

  gauge_reading_t   owed_readings[$];
  int               fail_count = 0;
  int               n_readings = 0;

  assign failures = fail_count;

  // Recompute the starting charge and forget the previous sample
  function automatic void restart_gauge();
    longint p;
    p = (pct > PCT_FULL) ? longint'(PCT_FULL) : longint'(pct);
    twice_used = longint'(cap_mah) * CHARGE_PER_PCT * (longint'(PCT_FULL) - p);
    prev_ma    = 0;
    prev_ms    = 0;
    have_prev  = 1'b0;
  endfunction

  // Add the trapezoid since the previous sample and form the reading
  function automatic gauge_reading_t integrate_sample(logic [CURRENT_BITS-1:0] raw_ma,
                                                      logic [TIME_W-1:0] raw_ms);
    longint ma, ms, dt, sum, num, den, q, half;
    gauge_reading_t r;
    ma = $signed(raw_ma);
    ms = raw_ms;
    if (have_prev) begin
      dt  = (ms > prev_ms) ? ms - prev_ms : 0;
      sum = twice_used + (prev_ma + ma) * dt;
      if (sum > TWICE_HI) sum = TWICE_HI;
      else if (sum < TWICE_LO) sum = TWICE_LO;
      twice_used = sum;
    end
    prev_ma   = ma;
    prev_ms   = ms;
    have_prev = 1'b1;

    // Floor of half the doubled charge, clamped to the output range
    half = twice_used >>> 1;
    if (half > OUT_HI) half = OUT_HI;
    else if (half < OUT_LO) half = OUT_LO;
    r.used        = half[USED_W-1:0];
    r.charging    = (ma < 0);
    r.no_estimate = (ma == 0);

    // Time until full while charging, until empty while discharging
    if (ma == 0) begin
      r.ttl = '0;
    end else begin
      if (ma < 0) begin
        num = twice_used;
        den = -2 * ma;
      end else begin
        num = longint'(cap_mah) * 2 * MS_PER_HOUR - twice_used;
        den = 2 * ma;
      end
      q = (num <= 0) ? 0 : num / den;
      if (q > TTL_TOP) q = TTL_TOP;
      r.ttl = q[TTL_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: reading %0d %s mismatch: expected %0h, actual %0h",
               $time, n_readings, what, want, got);
      fail_count++;
    end
  endtask

  // Follow configuration writes, check result transfers, predict on sample transfers
  always @(posedge clk) begin
    gauge_reading_t want;
    gauge_reading_t got;
    if (rst) begin
      cap_mah = CAP_RESET;
      pct     = PCT_FULL;
      restart_gauge();
      owed_readings.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CAPACITY) begin
          cap_mah = cfg_data[CAP_W-1:0];
          restart_gauge();
        end else if (cfg_index == REG_PERCENT) begin
          pct = cfg_data[PCT_W-1:0];
          restart_gauge();
        end
      end

      if (m_tvalid && m_tready) begin
        got.used        = m_tdata[USED_W-1:0];
        got.ttl         = m_tdata[USED_W +: TTL_W];
        got.charging    = m_tuser[0];
        got.no_estimate = m_tuser[1];
        if (owed_readings.size() == 0) begin
          $display("%0t: unexpected reading: expected none, actual used %0h ttl %0h flags %b",
                   $time, got.used, got.ttl, m_tuser);
          fail_count++;
        end else begin
          want = owed_readings.pop_front();
          check_field("used_charge_mams", want.used, got.used);
          check_field("charging", want.charging, got.charging);
          check_field("time_to_limit_ms", want.ttl, got.ttl);
          check_field("no_estimate", want.no_estimate, got.no_estimate);
        end
        n_readings++;
      end

      if (s_tvalid && s_tready)
        owed_readings.push_back(integrate_sample(s_tdata[CURRENT_BITS-1:0],
                                                 s_tdata[CURRENT_BITS +: TIME_W]));
    end
    pending <= owed_readings.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the coulomb counter: clock, reset, sample and configuration stimulus, verdict.
module tb_top
  import bcc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CB       = CURRENT_BITS_DEFAULT;
  localparam int     SD_W     = ((CB + TIME_W + 7) / 8) * 8;
  localparam longint TIME_TOP = (64'sd1 <<< TIME_W) - 1;
  localparam logic signed [CB-1:0] MA_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] MA_MIN = {1'b1, {(CB-1){1'b0}}};

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic [SD_W-1:0]       s_tdata   = '0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire [USED_W+TTL_W-1:0] m_tdata;
  wire [1:0]             m_tuser;

  int                    failures;
  int                    pending;
  int                    delivered = 0;
  bit                    tx_calm   = 1'b0;
  bit                    rx_calm   = 1'b0;
  logic [TIME_W-1:0]     clock_ms  = '0;
  logic signed [CB-1:0]  last_ma   = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  battery_coulomb_counter_top #(.CURRENT_BITS(CB)) dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data
  );

  bcc_checker #(.CURRENT_BITS(CB)) checker_i (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data,
    .failures, .pending
  );

  // Count result transfers to time the long receiver hold-offs
  always @(posedge clk)
    if (m_tvalid && m_tready) delivered <= delivered + 1;

  // Mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Offer one sample and hold it until the transfer
  task automatic send_sample(input logic signed [CB-1:0] ma, input logic [TIME_W-1:0] ms);
    int n;
    logic [SD_W-1:0] word;
    n    = tx_calm ? 0 : pick_gap();
    word = '0;
    word[CB-1:0]       = ma;
    word[CB +: TIME_W] = ms;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait until every reading has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write one register once the block is idle and past its restart
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Write both registers; junk above the percent field must be ignored
  task automatic set_gauge(input logic [CAP_W-1:0] cap, input logic [PCT_W-1:0] pct);
    logic [CFG_DATA_W-1:0] pct_word;
    pct_word = CFG_DATA_W'($urandom());
    pct_word[PCT_W-1:0] = pct;
    write_reg(REG_CAPACITY, CFG_DATA_W'(cap));
    write_reg(REG_PERCENT, pct_word);
  endtask

  // Mostly advancing timestamps with varied currents, some jumps back and stray times
  task automatic run_mixed(input int count);
    int r;
    longint nxt;
    logic signed [CB-1:0] ma;
    logic [TIME_W-1:0] ms;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        ms = TIME_W'($urandom());
      end else if (r < 14) begin
        ms = clock_ms - TIME_W'($urandom_range(0, 100000));
      end else begin
        nxt = longint'(clock_ms) + ((r < 20) ? 0 : (r < 85) ? $urandom_range(1, 2000)
                                                           : $urandom_range(2001, 900000));
        ms = (nxt > TIME_TOP) ? TIME_W'($urandom_range(0, 1000)) : TIME_W'(nxt);
      end
      clock_ms = ms;

      r = $urandom_range(0, 99);
      if (r < 10) ma = '0;
      else if (r < 35) ma = CB'($urandom());
      else if (r < 50) ma = $urandom_range(0, 1) ? MA_MAX - CB'($urandom_range(0, 3))
                                                 : MA_MIN + CB'($urandom_range(0, 3));
      else if (r < 70) ma = CB'(int'(last_ma) + int'($urandom_range(0, 64)) - 32);
      else ma = CB'(int'($urandom_range(0, 4000)) - 2000);
      last_ma = ma;
      send_sample(ma, ms);
    end
  endtask

  // Receiver: random stalls, plus two long hold-offs that back the block up
  initial begin
    int n;
    int holds;
    holds = 0;
    while (rst) @(posedge clk);
    forever begin
      if ((holds == 0 && delivered >= 60) || (holds == 1 && delivered >= 900)) begin
        holds++;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        n = rx_calm ? 0 : pick_gap();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Sender: directed corners, random phases under several settings, then a drive to the clamps
  initial begin
    logic signed [CB-1:0] ma;
    logic [TIME_W-1:0] ms;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, nothing used: first sample, zero current, extremes, time going back
    send_sample(0, 0);
    send_sample(MA_MAX, 1000);
    send_sample(MA_MIN, 2000);
    send_sample(-1, 2000);
    send_sample(1, TIME_W'(TIME_TOP));
    send_sample(0, 5);
    send_sample(-7, 86399999);
    send_sample(300, 86399999);
    send_sample(0, 86400002);
    send_sample(-1, 86400005);
    send_sample(0, 86400008);

    // Largest capacity, empty battery: limit exactly reached, then passed
    set_gauge(CAP_W'(TIME_TOP), 0);
    send_sample(1, 10);
    send_sample(-1, 20);
    send_sample(1, 30);
    send_sample(0, 40);

    // Percent above one hundred on the smallest nonzero capacity
    set_gauge(1, 127);
    send_sample(5, 0);
    send_sample(5, 100);
    send_sample(-5, 200);

    // Zero capacity with percent just above one hundred
    set_gauge(0, 101);
    send_sample(10, 0);
    send_sample(10, 50);
    send_sample(-10, 60);

    // Full battery, largest capacity: estimate clamps at the top
    set_gauge(CAP_W'(TIME_TOP), 100);
    send_sample(1, 0);
    send_sample(MA_MIN, 1);

    // Random phases under different settings and idling
    set_gauge(1000, 50);
    run_mixed(120);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    set_gauge(1, 127);
    run_mixed(130);
    tx_calm = 1'b0;
    set_gauge(0, 0);
    run_mixed(100);
    rx_calm = 1'b0;
    set_gauge(CAP_W'($urandom()), PCT_W'($urandom_range(0, 127)));
    run_mixed(150);

    // Near-maximum discharge over whole-field time steps until the output saturates;
    // a slight charge now and then pushes the time to full past its top
    set_gauge(CAP_W'(TIME_TOP), 100);
    for (int i = 0; i < 1200; i++) begin
      ms = i[0] ? TIME_W'(TIME_TOP - $urandom_range(0, 15)) : TIME_W'($urandom_range(0, 15));
      ma = (i % 40 == 39) ? CB'(-int'($urandom_range(1, 3)))
                          : CB'(int'(MA_MAX) - int'($urandom_range(0, 287)));
      send_sample(ma, ms);
    end

    drain();
    repeat (40) @(posedge clk);
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
